[rtl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants
// Widths of the shared multi-limb multiply engine and its command struct.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int LIMB_W     = 32;
   localparam int LIMBS      = 12;
   localparam int ACC_W      = LIMB_W * LIMBS;
   localparam int OPD_W      = 2 * LIMB_W;
   localparam int LD_W       = 68;
   localparam int STEP_W     = $clog2(2 * LIMBS);
   localparam int LIMB_IDX_W = $clog2(LIMBS);
   localparam int INV_BITS   = 39;

   // polynomial constant term of the position factor, 10 * 2^78
   localparam logic [ACC_W-1:0] ADD_CONST = ACC_W'(10) << (2 * INV_BITS);

   typedef enum logic [1:0] {
      ENG_LOAD,
      ENG_MUL,
      ENG_ADD
   } eng_op_type;

   typedef struct packed {
      logic                 valid;
      eng_op_type           op;
      logic [LD_W-1:0]      ld_val;
      logic [OPD_W-1:0]     opd;
   } eng_cmd_type;

endpackage

[rtl/qte_mul_engine.sv]
// ----------------------------------------------------------------------------
// qte_mul_engine: shared wide multiply unit, with load and constant-add commands
// Holds a 384-bit accumulator; multiplies it by a 64-bit operand one 32x32
// partial product per cycle, top limb first, modulo 2^384.
// ----------------------------------------------------------------------------
module qte_mul_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  qte_pkg::eng_cmd_type        cmd,
   output logic                        busy,
   output logic [qte_pkg::ACC_W-1:0]   acc
);
   import qte_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * LIMBS - 1);

   logic [ACC_W-1:0]      acc_ff;
   logic [ACC_W-1:0]      src_ff;
   logic [OPD_W-1:0]      opd_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  run_ff;
   logic [OPD_W-1:0]      prod_ff;
   logic [OPD_W-1:0]      prod_in;
   logic                  prod_vld_ff;
   logic                  prod_hi_ff;
   logic [LIMB_IDX_W-1:0] limb_idx;
   logic [LIMB_W-1:0]     limb;
   logic [LIMB_W-1:0]     half;

   assign limb_idx = LIMB_IDX_W'(LIMBS - 1) - LIMB_IDX_W'(step_ff[STEP_W-1:1]);
   assign limb     = src_ff[limb_idx*LIMB_W +: LIMB_W];
   assign half     = step_ff[0] ? opd_ff[OPD_W-1:LIMB_W] : opd_ff[LIMB_W-1:0];
   assign prod_in  = OPD_W'(limb) * OPD_W'(half);

   assign busy = run_ff | prod_vld_ff;
   assign acc  = acc_ff;

   // sequencing of partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         step_ff     <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= run_ff;
         if (cmd.valid && cmd.op == ENG_MUL) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            if (step_ff == STEP_LAST) begin
               run_ff <= 1'b0;
            end
            step_ff <= STEP_W'(step_ff + 1'b1);
         end
      end
   end

   // accumulator datapath
   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      prod_hi_ff <= step_ff[0];
      if (cmd.valid) begin
         unique case (cmd.op)
            ENG_LOAD: acc_ff <= {{(ACC_W-LD_W){cmd.ld_val[LD_W-1]}}, cmd.ld_val};
            ENG_MUL: begin
               src_ff <= acc_ff;
               opd_ff <= cmd.opd;
               acc_ff <= '0;
            end
            ENG_ADD: acc_ff <= acc_ff + ADD_CONST;
            default: acc_ff <= acc_ff;
         endcase
      end else if (prod_vld_ff) begin
         if (prod_hi_ff) begin
            acc_ff <= acc_ff + (ACC_W'(prod_ff) << LIMB_W);
         end else begin
            acc_ff <= (acc_ff << LIMB_W) + ACC_W'(prod_ff);
         end
      end
   end

   ap_mul_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.valid && cmd.op == ENG_MUL |=> run_ff && step_ff == '0)
      else $error("multiply did not start");
   ap_prod_follows_run: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> $past(run_ff))
      else $error("partial product without issue");
   ap_step_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> step_ff <= STEP_LAST)
      else $error("step counter out of range");

endmodule

[rtl/quintic_trajectory_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator_unit: minimum-jerk trajectory evaluator
// Plans a point-to-point quintic move and evaluates position, velocity and
// acceleration at a given time.
// ----------------------------------------------------------------------------
// plan transfer: stalls while dividing (one restoring divide bit per cycle), no result
// evaluate transfer: result after 17 wide multiplies in the shared engine,
//   one item in flight at a time
// result sits in an output register, so a new item may enter while it waits
// synchronous active-high reset: control and configuration registers to reset values, planned move zero
module quintic_trajectory_evaluator_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [23:0]        req_eval_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_position,
   output logic signed [47:0] rsp_velocity,
   output logic signed [47:0] rsp_acceleration,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import qte_pkg::*;

   // register indexes
   localparam logic [1:0] CSR_INIT_POS  = 2'd0;
   localparam logic [1:0] CSR_FINAL_POS = 2'd1;
   localparam logic [1:0] CSR_DURATION  = 2'd2;

   localparam logic ACT_PLAN = 1'b0;

   localparam int OUT_W = 48;
   localparam int MAG_W = 51;
   localparam int SUM_W = 64;
   localparam int X_W   = 64;
   localparam int SH_POS = 5 * INV_BITS - FRAC_BITS;
   localparam int SH_VEL = 5 * INV_BITS - 2 * FRAC_BITS;
   localparam int SH_ACC = 5 * INV_BITS - 3 * FRAC_BITS;
   localparam logic [X_W-1:0] ONE_X = X_W'(1) << INV_BITS;
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(48'sh7FFF_FFFF_FFFF);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - SUM_W'(1);

   // program counter positions of the three result captures
   localparam logic [4:0] PC_CAP_POS = 5'd7;
   localparam logic [4:0] PC_CAP_VEL = 5'd15;
   localparam logic [4:0] PC_CAP_ACC = 5'd23;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MULX,
      ST_PREP,
      ST_ISSUE,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type          state_ff;
   logic signed [31:0] init_pos_ff;
   logic signed [31:0] final_pos_ff;
   logic [23:0]        duration_ff;
   logic signed [32:0] dist_ff;
   logic signed [31:0] start_ff;
   logic [39:0]        inv_ff;
   logic [23:0]        time_ff;
   logic [X_W-1:0]     x_ff;
   logic [X_W-1:0]     dx_ff;
   logic [65:0]        d2_ff;
   logic               aneg_ff;
   logic [4:0]         pc_ff;
   logic [5:0]         div_cnt_ff;
   logic [24:0]        rem_ff;
   logic [39:0]        quo_ff;
   logic [23:0]        div_d_ff;
   logic [OUT_W-1:0]   pos_ff;
   logic [OUT_W-1:0]   vel_ff;
   logic [OUT_W-1:0]   acc_res_ff;
   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   rsp_pos_ff;
   logic [OUT_W-1:0]   rsp_vel_ff;
   logic [OUT_W-1:0]   rsp_acc_ff;

   eng_cmd_type        eng_cmd;
   logic               eng_busy;
   logic [ACC_W-1:0]   eng_acc;

   logic               dneg;
   logic [X_W-1:0]     dmag;
   logic [24:0]        rem_sh;
   logic               qbit;
   logic [24:0]        rem_in;
   logic [39:0]        quo_in;
   logic [64:0]        two_x;
   logic [LD_W-1:0]    pos_load;
   logic               is_cap;
   logic               rsp_load;
   logic [ACC_W-1:0]   cap_shifted;
   logic [MAG_W-1:0]   mag;
   logic signed [SUM_W-1:0] mag_s;
   logic signed [SUM_W-1:0] start_scaled;
   logic signed [SUM_W-1:0] pos_sum;
   logic signed [SUM_W-1:0] vel_sum;
   logic signed [SUM_W-1:0] acc_sum;

   function automatic logic [OUT_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
      logic [OUT_W-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[OUT_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_velocity     = rsp_vel_ff;
   assign rsp_acceleration = rsp_acc_ff;

   // output register takes a new result once it is free or being taken
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // distance sign and magnitude (magnitude at most 2^32)
   assign dneg = dist_ff[32];
   assign dmag = dneg ? X_W'(-dist_ff) : X_W'(dist_ff);

   // restoring divide step for 2^39 / duration, dividend has a single one bit
   assign rem_sh = {rem_ff[23:0], (div_cnt_ff == 6'(INV_BITS))};
   assign qbit   = (rem_sh >= {1'b0, div_d_ff});
   assign rem_in = qbit ? 25'(rem_sh - {1'b0, div_d_ff}) : rem_sh;
   assign quo_in = {quo_ff[38:0], qbit};

   assign two_x = {x_ff, 1'b0};
   // 6x - 15 * 2^39, may be negative
   assign pos_load = LD_W'({x_ff, 2'b00}) + LD_W'({x_ff, 1'b0})
                   - (LD_W'(15) << INV_BITS);

   // command program for the shared multiply engine
   always_comb begin
      eng_cmd = '0;
      eng_cmd.op = ENG_MUL;
      is_cap = 1'b0;
      unique case (pc_ff)
         5'd0:  begin eng_cmd.op = ENG_LOAD; eng_cmd.ld_val = pos_load; end
         5'd1:  eng_cmd.opd = x_ff;
         5'd2:  eng_cmd.op = ENG_ADD;
         5'd3:  eng_cmd.opd = x_ff;
         5'd4:  eng_cmd.opd = x_ff;
         5'd5:  eng_cmd.opd = x_ff;
         5'd6:  eng_cmd.opd = dmag;
         5'd8:  begin eng_cmd.op = ENG_LOAD; eng_cmd.ld_val = LD_W'(x_ff); end
         5'd9:  eng_cmd.opd = x_ff;
         5'd10: eng_cmd.opd = dx_ff;
         5'd11: eng_cmd.opd = dx_ff;
         5'd12: eng_cmd.opd = X_W'(30);
         5'd13: eng_cmd.opd = X_W'(inv_ff);
         5'd14: eng_cmd.opd = dmag;
         5'd16: begin eng_cmd.op = ENG_LOAD; eng_cmd.ld_val = LD_W'(d2_ff); end
         5'd17: eng_cmd.opd = x_ff;
         5'd18: eng_cmd.opd = dx_ff;
         5'd19: eng_cmd.opd = X_W'(60);
         5'd20: eng_cmd.opd = X_W'(inv_ff);
         5'd21: eng_cmd.opd = X_W'(inv_ff);
         5'd22: eng_cmd.opd = dmag;
         default: is_cap = 1'b1;
      endcase
      eng_cmd.valid = (state_ff == ST_ISSUE) && !is_cap;
   end

   // scale down and cap the magnitude at 2^50
   always_comb begin
      case (pc_ff)
         PC_CAP_POS: cap_shifted = eng_acc >> SH_POS;
         PC_CAP_VEL: cap_shifted = eng_acc >> SH_VEL;
         default:    cap_shifted = eng_acc >> SH_ACC;
      endcase
      mag = (|cap_shifted[ACC_W-1:MAG_W-1]) ? (MAG_W'(1) << (MAG_W - 1))
                                            : {1'b0, cap_shifted[MAG_W-2:0]};
      mag_s        = SUM_W'(mag);
      start_scaled = SUM_W'(start_ff) <<< FRAC_BITS;
      pos_sum      = start_scaled + (dneg ? -mag_s : mag_s);
      vel_sum      = dneg ? -mag_s : mag_s;
      acc_sum      = aneg_ff ? -mag_s : mag_s;
   end

   qte_mul_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (eng_cmd),
      .busy  (eng_busy),
      .acc   (eng_acc)
   );

   // sequencer, registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         init_pos_ff  <= '0;
         final_pos_ff <= '0;
         duration_ff  <= 24'd65536;
         dist_ff      <= '0;
         start_ff     <= '0;
         inv_ff       <= '0;
         pc_ff        <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_INIT_POS:  init_pos_ff  <= csr_wdata;
               CSR_FINAL_POS: final_pos_ff <= csr_wdata;
               CSR_DURATION:  duration_ff  <= csr_wdata[23:0];
               default: ;
            endcase
         end
         // result transfer frees the output register unless a new one loads
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  time_ff <= req_eval_time;
                  if (req_action == ACT_PLAN) begin
                     dist_ff    <= 33'(final_pos_ff) - 33'(init_pos_ff);
                     start_ff   <= init_pos_ff;
                     div_d_ff   <= (duration_ff == '0) ? 24'd1 : duration_ff;
                     rem_ff     <= '0;
                     quo_ff     <= '0;
                     div_cnt_ff <= 6'(INV_BITS);
                     state_ff   <= ST_DIV;
                  end else begin
                     state_ff <= ST_MULX;
                  end
               end
            end
            ST_DIV: begin
               rem_ff     <= rem_in;
               quo_ff     <= quo_in;
               div_cnt_ff <= 6'(div_cnt_ff - 1'b1);
               if (div_cnt_ff == '0) begin
                  inv_ff   <= quo_in;
                  state_ff <= ST_IDLE;
               end
            end
            ST_MULX: begin
               x_ff     <= X_W'(time_ff) * X_W'(inv_ff);
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               dx_ff    <= (x_ff >= ONE_X) ? x_ff - ONE_X : ONE_X - x_ff;
               d2_ff    <= (two_x >= 65'(ONE_X)) ? 66'(two_x - 65'(ONE_X))
                                                 : 66'(65'(ONE_X) - two_x);
               aneg_ff  <= ((two_x < 65'(ONE_X)) != (x_ff < ONE_X)) != dneg;
               pc_ff    <= '0;
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               if (is_cap) begin
                  pc_ff <= 5'(pc_ff + 1'b1);
                  if (pc_ff == PC_CAP_POS) begin
                     pos_ff <= sat48(pos_sum);
                  end else if (pc_ff == PC_CAP_VEL) begin
                     vel_ff <= sat48(vel_sum);
                  end else begin
                     acc_res_ff <= sat48(acc_sum);
                     state_ff   <= ST_OUT;
                  end
               end else begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (!eng_busy) begin
                  pc_ff    <= 5'(pc_ff + 1'b1);
                  state_ff <= ST_ISSUE;
               end
            end
            ST_OUT: begin
               // load the output register once it is free or being taken
               if (rsp_load) begin
                  rsp_pos_ff   <= pos_ff;
                  rsp_vel_ff   <= vel_ff;
                  rsp_acc_ff   <= acc_res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   ap_cmd_not_busy: assert property (@(posedge clock) disable iff (reset)
      eng_cmd.valid |-> !eng_busy)
      else $error("engine command while engine busy");
   ap_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_d_ff != '0)
      else $error("divide by zero duration");
   ap_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");
   ap_cap_at_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> pc_ff == 5'(PC_CAP_ACC + 1))
      else $error("result before program end");

endmodule
